/* hw/rtl/mbp_pkg.sv */
// Shared types and constants for the MSB-first bit packer.
// Used by the front, queue, back and top-level modules; no dependencies.
package mbp_pkg;

  localparam int ValueWidth   = 64;
  localparam int CountWidth   = 6;
  localparam int CmdWidth     = 2;
  localparam int ByteWidth    = 8;
  localparam int MaxBits      = 32;
  localparam int MaxBytes     = 8;
  localparam int BufWidth     = 72;   // up to nine bytes per item
  localparam int NbWidth      = 4;    // byte count 0..9
  localparam int PartialWidth = 7;
  localparam int HeldWidth    = 3;
  localparam int InDataWidth  = 72;   // value and count, padded to whole bytes

  localparam int QueueDepthDefault = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_WRITE_BITS  = 2'd0,
    CMD_WRITE_BYTES = 2'd1,
    CMD_ALIGN       = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  // One queued job: bytes right aligned, first byte out is the highest one.
  typedef struct packed {
    logic [BufWidth-1:0] data;
    logic [NbWidth-1:0]  nbytes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/mbp_front.sv */
// Front end of the bit packer: accepts items, keeps the partial byte and
// turns each item into a job of whole bytes. Depends on mbp_pkg.
module mbp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mbp_pkg::InDataWidth-1:0]  s_axis_tdata,
  input  logic [mbp_pkg::CmdWidth-1:0]     s_axis_tuser,
  input  mbp_pkg::q_status_t               q_status,
  output logic                             push_valid,
  output mbp_pkg::job_t                    push_job
);
  import mbp_pkg::*;

  logic [PartialWidth-1:0] partial, partial_next;
  logic [HeldWidth-1:0]    held, held_next;

  cmd_t                  cmd;
  logic [ValueWidth-1:0] value;
  logic [CountWidth-1:0] count;
  logic                  accept;

  // bit-write path
  logic [CountWidth-1:0] nbits;
  logic [32:0]           bit_mask;
  logic [MaxBits-1:0]    vbits;
  logic [38:0]           acc;
  logic [38:0]           acc_sh;
  logic [CountWidth-1:0] total;
  logic [ByteWidth-1:0]  rem_mask;

  // align and byte-write path
  logic [NbWidth-1:0]    nbytes;
  logic [6:0]            byte_sh;
  logic [64:0]           byte_mask;
  logic [ValueWidth-1:0] vbytes;
  logic                  pad;
  logic [ByteWidth-1:0]  pad_byte;
  logic [BufWidth-1:0]   pad_word;

  job_t job;

  assign cmd   = cmd_t'(s_axis_tuser);
  assign value = s_axis_tdata[ValueWidth-1:0];
  assign count = s_axis_tdata[ValueWidth +: CountWidth];

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Join held bits with the new field and split off whole bytes
  always_comb begin
    nbits    = (count > CountWidth'(MaxBits)) ? CountWidth'(MaxBits) : count;
    bit_mask = (33'd1 << nbits) - 33'd1;
    vbits    = value[MaxBits-1:0] & bit_mask[MaxBits-1:0];
    acc      = ({32'd0, partial} << nbits) | {7'd0, vbits};
    total    = {3'd0, held} + nbits;
    acc_sh   = acc >> total[2:0];
    rem_mask = (8'd1 << total[2:0]) - 8'd1;
  end

  // Pad the partial byte, then take the low whole bytes of value
  always_comb begin
    if (cmd == CMD_WRITE_BYTES) begin
      nbytes = (count > CountWidth'(MaxBytes)) ? NbWidth'(MaxBytes) : count[NbWidth-1:0];
    end else begin
      nbytes = '0;
    end
    byte_sh   = {nbytes, 3'b000};
    byte_mask = (65'd1 << byte_sh) - 65'd1;
    vbytes    = value & byte_mask[ValueWidth-1:0];
    pad       = (held != '0);
    pad_byte  = ByteWidth'({1'b0, partial} << (4'd8 - {1'b0, held}));
    pad_word  = {64'd0, pad_byte} << byte_sh;
  end

  // Decode the command into a job and the next partial state
  always_comb begin
    job          = '0;
    partial_next = partial;
    held_next    = held;
    unique case (cmd)
      CMD_WRITE_BITS: begin
        job.data     = {33'd0, acc_sh};
        job.nbytes   = {1'b0, total[5:3]};
        partial_next = acc[PartialWidth-1:0] & rem_mask[PartialWidth-1:0];
        held_next    = total[2:0];
      end
      CMD_WRITE_BYTES, CMD_ALIGN: begin
        job.data     = {8'd0, vbytes} | (pad ? pad_word : '0);
        job.nbytes   = nbytes + {3'd0, pad};
        partial_next = '0;
        held_next    = '0;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // Drop jobs that complete no byte
  assign push_valid = accept && (job.nbytes != '0);
  assign push_job   = job;

  // Advance the partial byte on every transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      held    <= '0;
    end else if (accept) begin
      partial <= partial_next;
      held    <= held_next;
    end
  end

endmodule

/* hw/rtl/mbp_queue.sv */
// Short job queue between the front and back of the bit packer.
// Register-based FIFO of job_t entries. Depends on mbp_pkg.
module mbp_queue #(
  parameter int DEPTH = mbp_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mbp_pkg::job_t       push_job,
  input  logic                pop,
  output mbp_pkg::job_t       head_job,
  output mbp_pkg::q_status_t  q_status
);
  import mbp_pkg::*;

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);

  job_t                entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] fill;
  logic                do_push, do_pop;

  assign q_status.full  = (fill == CntWidth'(DEPTH));
  assign q_status.empty = (fill == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head_job       = entries[rd_ptr];

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/mbp_back.sv */
// Back end of the bit packer: takes jobs from the queue and sends their
// bytes one transfer per cycle while the receiver is ready, highest byte first. Depends on mbp_pkg.
module mbp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mbp_pkg::q_status_t            q_status,
  input  mbp_pkg::job_t                 head_job,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mbp_pkg::ByteWidth-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import mbp_pkg::*;

  logic                active;
  logic [BufWidth-1:0] data;
  logic [NbWidth-1:0]  idx;
  logic                xfer;

  assign xfer = m_axis_tvalid && m_axis_tready;

  // Load the next job when idle or when the final byte leaves
  assign pop = !q_status.empty && (!active || (xfer && idx == '0));

  assign m_axis_tvalid = active;
  assign m_axis_tdata  = data[{idx, 3'b000} +: ByteWidth];
  assign m_axis_tlast  = (idx == '0);

  // Hold the current job and step down through its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (xfer && idx == '0) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data <= head_job.data;
      idx  <= head_job.nbytes - 1'b1;
    end else if (xfer) begin
      idx  <= idx - 1'b1;
    end
  end

endmodule

/* hw/rtl/msb_first_bit_packer_unit.sv */
// MSB-first bit packer: appends bit fields and whole bytes to a byte stream.
// Jobs are registered in the queue, then loaded into the back end to be sent.
// Throughput: input takes one item per cycle while the job queue has room;
// output sends one byte per cycle while m_axis_tready is high.
// Reset: synchronous; clears the partial byte, the queue and the output.
// Depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
module msb_first_bit_packer_unit #(
  parameter int QUEUE_DEPTH = mbp_pkg::QueueDepthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [63:0] value, [69:64] count, [71:70] zero
  input  logic [mbp_pkg::InDataWidth-1:0] s_axis_tdata,
  // [1:0] command
  input  logic [mbp_pkg::CmdWidth-1:0]    s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] out_byte
  output logic [mbp_pkg::ByteWidth-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);
  import mbp_pkg::*;

  q_status_t q_status;
  logic      push_valid;
  job_t      push_job;
  logic      pop;
  job_t      head_job;

  mbp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status      (q_status),
    .push_valid    (push_valid),
    .push_job      (push_job)
  );

  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push_valid),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  mbp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head_job      (head_job),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A queued job carries one to nine bytes
  a_job_size: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_job.nbytes != '0 && push_job.nbytes <= NbWidth'(MaxBytes + 1)))
    else $error("job with bad byte count");

  // A byte that is not the last of its item is followed by another
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("output dropped valid inside an item");

  // Reset leaves the output idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

/* bench/testbench.sv */
// Self-checking bench for msb_first_bit_packer_unit: directed table, then random fields.
// Expected bytes: typed table rows, else a bit-level packer model; depends on mbp_pkg.
module testbench;
  import mbp_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_ITEMS     = 430;
  localparam int QUIET_TAIL       = 60;
  localparam int LONG_HOLD_AT     = 100;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SENDER_PAUSE_AT  = 250;
  localparam int DRAIN_CYCLES     = 20;
  localparam int TIMEOUT_CYCLES   = 300000;
  localparam int NUM_DIRECTED     = 24;

  // One byte on the output stream
  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 last;
  } out_beat_t;

  // One directed row; bytes_typed holds the first byte in the top bits
  typedef struct packed {
    cmd_t                  cmd;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] count;
    logic                  typed;
    logic [NbWidth-1:0]    nbytes_typed;
    logic [BufWidth-1:0]   bytes_typed;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // already aligned after reset: nothing out
    '{CMD_ALIGN,       64'h0,                   6'd0,  1'b1, 4'd0, 72'h0},
    // zero bit count
    '{CMD_WRITE_BITS,  64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b1, 4'd0, 72'h0},
    '{CMD_WRITE_BITS,  64'h0000_0000_0000_00A5, 6'd8,  1'b1, 4'd1,
      72'hA5_00_00_00_00_00_00_00_00},
    // full 32-bit field, upper value bits dropped
    '{CMD_WRITE_BITS,  64'hFFFF_FFFF_1234_5678, 6'd32, 1'b1, 4'd4,
      72'h12_34_56_78_00_00_00_00_00},
    // bit count above the limit writes 32 bits
    '{CMD_WRITE_BITS,  64'h0000_0000_DEAD_BEEF, 6'd63, 1'b1, 4'd4,
      72'hDE_AD_BE_EF_00_00_00_00_00},
    '{CMD_WRITE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 6'd8,  1'b1, 4'd8,
      72'hFF_FF_FF_FF_FF_FF_FF_FF_00},
    // byte count above the limit writes 8 bytes
    '{CMD_WRITE_BYTES, 64'h0123_4567_89AB_CDEF, 6'd63, 1'b1, 4'd8,
      72'h01_23_45_67_89_AB_CD_EF_00},
    // partial byte only: no completed byte
    '{CMD_WRITE_BITS,  64'h0000_0000_0000_0005, 6'd3,  1'b1, 4'd0, 72'h0},
    // zero byte count only pads
    '{CMD_WRITE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b1, 4'd1,
      72'hA0_00_00_00_00_00_00_00_00},
    '{CMD_WRITE_BITS,  64'h0000_0000_0000_0001, 6'd1,  1'b1, 4'd0, 72'h0},
    // pad plus eight bytes: nine results
    '{CMD_WRITE_BYTES, 64'h1122_3344_5566_7788, 6'd8,  1'b1, 4'd9,
      72'h80_11_22_33_44_55_66_77_88},
    '{CMD_WRITE_BITS,  64'h0000_0000_0000_000F, 6'd4,  1'b1, 4'd0, 72'h0},
    // unknown command is dropped, held bits kept
    '{CMD_NONE,        64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, 4'd0, 72'h0},
    '{CMD_ALIGN,       64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, 4'd1,
      72'hF0_00_00_00_00_00_00_00_00},
    '{CMD_WRITE_BITS,  64'h0000_0000_0000_007F, 6'd7,  1'b1, 4'd0, 72'h0},
    '{CMD_WRITE_BITS,  64'h0,                   6'd1,  1'b1, 4'd1,
      72'hFE_00_00_00_00_00_00_00_00},
    '{CMD_WRITE_BITS,  64'h0000_0000_0000_0013, 6'd5,  1'b0, 4'd0, 72'h0},
    '{CMD_WRITE_BITS,  64'h0000_0000_000A_5C3F, 6'd20, 1'b0, 4'd0, 72'h0},
    '{CMD_WRITE_BYTES, 64'h0000_0000_0000_00AB, 6'd1,  1'b0, 4'd0, 72'h0},
    '{CMD_WRITE_BITS,  64'hFFFF_FFFF_8000_0001, 6'd33, 1'b0, 4'd0, 72'h0},
    '{CMD_WRITE_BYTES, 64'h8000_0000_0000_0001, 6'd9,  1'b0, 4'd0, 72'h0},
    '{CMD_ALIGN,       64'h0,                   6'd0,  1'b0, 4'd0, 72'h0},
    '{CMD_WRITE_BITS,  64'h0,                   6'd32, 1'b0, 4'd0, 72'h0},
    '{CMD_NONE,        64'h0,                   6'd0,  1'b1, 4'd0, 72'h0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataWidth-1:0] s_axis_tdata = '0;
  logic [CmdWidth-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [ByteWidth-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;

  // Packer model state and the bytes still owed by the block
  logic [PartialWidth-1:0] held_bits = '0;
  logic [HeldWidth-1:0]    held_count = '0;
  logic [ByteWidth-1:0]    item_bytes[$];
  out_beat_t               pending_beats[$];

  int error_count = 0;
  bit receiver_idling = 1'b1;
  bit long_hold_req = 1'b0;

  msb_first_bit_packer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shift one bit into the partial byte; collect the byte once eight are held
  function automatic void shift_in_bit(logic b);
    logic [ByteWidth-1:0] acc;
    acc = {held_bits, b};
    if (held_count == 3'd7) begin
      item_bytes.push_back(acc);
      held_bits  = '0;
      held_count = '0;
    end else begin
      held_bits  = acc[PartialWidth-1:0];
      held_count = held_count + 3'd1;
    end
  endfunction

  function automatic void pad_to_byte();
    while (held_count != 0) shift_in_bit(1'b0);
  endfunction

  // Work out the bytes one item completes, in stream order
  function automatic void pack_item(cmd_t cmd, logic [ValueWidth-1:0] value,
                                    logic [CountWidth-1:0] count);
    int nbits;
    int i;
    item_bytes.delete();
    case (cmd)
      CMD_WRITE_BITS: begin
        nbits = (count > MaxBits) ? MaxBits : int'(count);
        for (i = nbits - 1; i >= 0; i--) shift_in_bit(value[i]);
      end
      CMD_WRITE_BYTES: begin
        pad_to_byte();
        nbits = ((count > MaxBytes) ? MaxBytes : int'(count)) * ByteWidth;
        for (i = nbits - 1; i >= 0; i--) shift_in_bit(value[i]);
      end
      CMD_ALIGN: pad_to_byte();
      default: ;
    endcase
  endfunction

  // Offer one item, hold it until transfer, then queue the bytes it owes
  task automatic offer_item(input cmd_t cmd, input logic [ValueWidth-1:0] value,
                            input logic [CountWidth-1:0] count, input logic typed,
                            input logic [NbWidth-1:0] nbytes_typed,
                            input logic [BufWidth-1:0] bytes_typed);
    int k;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, count, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pack_item(cmd, value, count);
    if (typed) begin
      item_bytes.delete();
      for (k = 0; k < nbytes_typed; k++)
        item_bytes.push_back(bytes_typed[BufWidth-1-ByteWidth*k -: ByteWidth]);
    end
    for (k = 0; k < item_bytes.size(); k++)
      pending_beats.push_back('{data: item_bytes[k], last: (k == item_bytes.size() - 1)});
  endtask

  // Check each output transfer against the oldest owed byte
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected transfer: out_byte=%02h last=%0b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus: directed table, then random fields
  initial begin
    stim_row_t row;
    cmd_t cmd;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] count;
    int pick;
    int n_sent;
    bit quiet;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      offer_item(row.cmd, row.value, row.count, row.typed, row.nbytes_typed, row.bytes_typed);
    end

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 99);
      value = {$urandom, $urandom};
      if (pick < 55) begin
        cmd   = CMD_WRITE_BITS;
        count = ($urandom_range(0, 9) == 0) ? CountWidth'($urandom_range(33, 63)) :
                                              CountWidth'($urandom_range(0, 32));
      end else if (pick < 80) begin
        cmd   = CMD_WRITE_BYTES;
        count = ($urandom_range(0, 9) == 0) ? CountWidth'($urandom_range(9, 63)) :
                                              CountWidth'($urandom_range(0, 8));
      end else if (pick < 92) begin
        cmd   = CMD_ALIGN;
        count = CountWidth'($urandom_range(0, 63));
      end else begin
        cmd   = CMD_NONE;
        count = CountWidth'($urandom_range(0, 63));
      end

      // Keep the tail free of idling; keep feeding while the receiver holds off
      quiet = (n_sent >= RANDOM_ITEMS - QUIET_TAIL) ||
              (n_sent >= LONG_HOLD_AT && n_sent < LONG_HOLD_AT + 30);
      if (n_sent >= RANDOM_ITEMS - QUIET_TAIL) receiver_idling = 1'b0;
      if (n_sent == LONG_HOLD_AT) long_hold_req = 1'b1;

      if (n_sent == SENDER_PAUSE_AT) begin
        // Drain the block completely before going on
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_beats.size() != 0);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end

      offer_item(cmd, value, count, 1'b0, '0, '0);
      n_sent++;
    end

    // Wait for every owed byte, then watch for strays
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
